// ===== rtl/mclt_pkg.sv =====
// Package for the config line tokenizer: widths, event and phase codes, types.
// Used by every module of the tokenizer; depends on nothing.
package mclt_pkg;

	localparam int OFFSET_BITS = 20;
	localparam int LINE_BITS   = 16;
	localparam int QDEPTH      = 4;
	localparam int QPTR_BITS   = $clog2(QDEPTH);

	localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
	localparam logic [LINE_BITS-1:0]   LIN_MAX = '1;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LBR   = 8'h7B;
	localparam logic [7:0] CH_RBR   = 8'h7D;

	localparam logic [7:0] KW_DEFINE [6] = '{8'h64, 8'h65, 8'h66, 8'h69, 8'h6E, 8'h65};
	localparam logic [2:0] KW_LEN = 3'd6;

	// config register indexes
	localparam logic CFG_FORMAT = 1'b0;
	localparam logic CFG_START  = 1'b1;

	// event kinds
	localparam logic [1:0] EV_OBJECT = 2'd0;
	localparam logic [1:0] EV_ROOT   = 2'd1;
	localparam logic [1:0] EV_ARG    = 2'd2;
	localparam logic [1:0] EV_ERROR  = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NO_DEFINE = 3'd0;
	localparam logic [2:0] ERR_NO_NAME   = 3'd1;
	localparam logic [2:0] ERR_NO_BRACE  = 3'd2;
	localparam logic [2:0] ERR_TRAILING  = 3'd3;
	localparam logic [2:0] ERR_STATUS    = 3'd4;
	localparam logic [2:0] ERR_NO_EQUALS = 3'd5;
	localparam logic [2:0] ERR_NONE      = 3'd0;

	typedef enum logic [3:0] {
		PH_START, PH_BLANK, PH_LCOMMENT, PH_PCOMMENT, PH_KEYWORD, PH_GAP1,
		PH_NAME, PH_GAP2, PH_TRAIL_OBJ, PH_TRAIL_CLOSE, PH_ARG_NAME,
		PH_SEEK_EQ, PH_VGAP, PH_VALUE, PH_ERR_SKIP
	} phase_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [OFFSET_BITS-1:0] name_offset;
		logic [OFFSET_BITS-1:0] name_length;
		logic [OFFSET_BITS-1:0] value_offset;
		logic [OFFSET_BITS-1:0] value_length;
		logic                   has_value;
		logic [LINE_BITS-1:0]   line_number;
		logic [2:0]             code;
	} event_t;

	// one queue entry holds all events of one byte (one or two)
	typedef struct packed {
		logic   two;
		event_t ev0;
		event_t ev1;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	function automatic logic [OFFSET_BITS-1:0] sat_ofs(input logic [OFFSET_BITS-1:0] v);
		return (v == OFS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
		return (v == LIN_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== rtl/mclt_front.sv =====
// Front end: byte parser state machine that turns each byte into zero to two events.
// Depends on mclt_pkg.
module mclt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        text_byte,
	input  logic              last,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic              cfg_data,
	output mclt_pkg::push_t   push
);
	import mclt_pkg::*;

	phase_t                 phase_q;
	logic [2:0]             kidx_q;
	logic [OFFSET_BITS-1:0] bpos_q, nstart_q, ncount_q, vstart_q, vcount_q;
	logic [LINE_BITS-1:0]   lcount_q;
	logic                   in_body_q, obj_seen_q, pcr_q, stopped_q;
	logic                   fmt_q, sia_q;

	phase_t                 ph;
	logic [2:0]             ki;
	logic [OFFSET_BITS-1:0] bp, ns, nc, vs, vc;
	logic [LINE_BITS-1:0]   lc;
	logic                   ib, os, pcr, stp;
	logic                   prim, root, skip;
	event_t                 prim_ev, root_ev;
	logic                   eol, blank;
	logic [2:0]             objerr;

	always_comb begin
		ph = phase_q; ki = kidx_q; bp = bpos_q; ns = nstart_q; nc = ncount_q;
		vs = vstart_q; vc = vcount_q; lc = lcount_q; ib = in_body_q; os = obj_seen_q;
		pcr = pcr_q; stp = stopped_q;
		prim = 1'b0; root = 1'b0; skip = 1'b0;
		prim_ev = '0; root_ev = '0;
		eol = (text_byte == CH_CR) || (text_byte == CH_LF);
		blank = (text_byte == CH_SPACE) || (text_byte == CH_TAB);
		objerr = fmt_q ? ERR_STATUS : ERR_NO_BRACE;

		if (!stp) begin
			if (text_byte != CH_NUL) begin
				// drop the LF of a CR LF pair
				if (pcr) begin
					pcr = 1'b0;
					if (text_byte == CH_LF && ph == PH_START)
						skip = 1'b1;
				end
				if (!skip) begin
					case (ph)
						PH_START, PH_BLANK: begin
							if (blank)
								ph = PH_BLANK;
							else if (eol) begin
								lc = sat_line(lc); pcr = (text_byte == CH_CR); ph = PH_START;
							end else if (text_byte == CH_HASH || text_byte == CH_SEMI)
								ph = PH_LCOMMENT;
							else if (ib) begin
								if (text_byte == CH_RBR)
									ph = PH_TRAIL_CLOSE;
								else if (fmt_q && text_byte == CH_EQ) begin
									ns = bp; nc = '0; vs = '0; vc = '0; ph = PH_VGAP;
								end else begin
									ns = bp; nc = OFFSET_BITS'(1); vs = '0; vc = '0;
									ph = PH_ARG_NAME;
								end
							end else if (!fmt_q) begin
								if (text_byte == KW_DEFINE[0]) begin
									ki = 3'd1; ph = PH_KEYWORD;
								end else begin
									prim = 1'b1; prim_ev.kind = EV_ERROR;
									prim_ev.line_number = lc; prim_ev.code = ERR_NO_DEFINE;
									stp = 1'b1;
								end
							end else if (text_byte == CH_LBR) begin
								ns = bp; nc = '0; vs = '0; vc = '0; ph = PH_TRAIL_OBJ;
							end else begin
								ns = bp; nc = OFFSET_BITS'(1); vs = '0; vc = '0; ph = PH_NAME;
							end
						end
						PH_LCOMMENT, PH_PCOMMENT: begin
							if (eol) begin
								lc = sat_line(lc); pcr = (text_byte == CH_CR); ph = PH_START;
							end
						end
						PH_KEYWORD: begin
							if (ki < KW_LEN) begin
								if (text_byte == KW_DEFINE[ki])
									ki = ki + 3'd1;
								else begin
									prim = 1'b1; prim_ev.kind = EV_ERROR;
									prim_ev.line_number = lc; prim_ev.code = ERR_NO_DEFINE;
									stp = 1'b1;
								end
							end else if (blank)
								ph = PH_GAP1;
							else begin
								ki = ERR_NO_DEFINE; ph = PH_ERR_SKIP;
							end
						end
						PH_GAP1: begin
							if (!blank) begin
								if (eol || text_byte == CH_LBR) begin
									ki = ERR_NO_NAME; ph = PH_ERR_SKIP;
								end else begin
									ns = bp; nc = OFFSET_BITS'(1); vs = '0; vc = '0;
									ph = PH_NAME;
								end
							end
						end
						PH_NAME: begin
							if (blank)
								ph = PH_GAP2;
							else if (text_byte == CH_LBR)
								ph = PH_TRAIL_OBJ;
							else if (eol) begin
								ki = objerr; ph = PH_ERR_SKIP;
							end else
								nc = sat_ofs(nc);
						end
						PH_GAP2: begin
							if (!blank) begin
								if (text_byte == CH_LBR)
									ph = PH_TRAIL_OBJ;
								else begin
									ki = objerr; ph = PH_ERR_SKIP;
								end
							end
						end
						PH_TRAIL_OBJ: begin
							if (!blank) begin
								if (eol || text_byte == CH_SEMI) begin
									prim = 1'b1; prim_ev.kind = EV_OBJECT;
									prim_ev.name_offset = ns; prim_ev.name_length = nc;
									prim_ev.line_number = lc;
									ib = 1'b1; os = 1'b1;
									if (eol) begin
										lc = sat_line(lc); pcr = (text_byte == CH_CR);
										ph = PH_START;
									end else
										ph = PH_PCOMMENT;
								end else begin
									ki = ERR_TRAILING; ph = PH_ERR_SKIP;
								end
							end
						end
						PH_TRAIL_CLOSE: begin
							if (!blank) begin
								if (eol) begin
									ib = 1'b0; lc = sat_line(lc); pcr = (text_byte == CH_CR);
									ph = PH_START;
								end else if (text_byte == CH_SEMI) begin
									ib = 1'b0; ph = PH_PCOMMENT;
								end else begin
									ki = ERR_TRAILING; ph = PH_ERR_SKIP;
								end
							end
						end
						PH_ARG_NAME: begin
							if (eol) begin
								prim = 1'b1;
								lc = sat_line(lc); pcr = (text_byte == CH_CR); ph = PH_START;
							end else if (blank)
								ph = fmt_q ? PH_SEEK_EQ : PH_VGAP;
							else if (fmt_q && text_byte == CH_EQ)
								ph = PH_VGAP;
							else
								nc = sat_ofs(nc);
						end
						PH_SEEK_EQ: begin
							if (!blank) begin
								if (text_byte == CH_EQ)
									ph = PH_VGAP;
								else begin
									ki = ERR_NO_EQUALS; ph = PH_ERR_SKIP;
								end
							end
						end
						PH_VGAP, PH_VALUE: begin
							if (eol) begin
								prim = 1'b1;
								lc = sat_line(lc); pcr = (text_byte == CH_CR); ph = PH_START;
							end else if (text_byte == CH_SEMI) begin
								prim = 1'b1; ph = PH_PCOMMENT;
							end else if (ph == PH_VALUE)
								vc = sat_ofs(vc);
							else if (!blank) begin
								vs = bp; vc = OFFSET_BITS'(1); ph = PH_VALUE;
							end
						end
						PH_ERR_SKIP: begin
							if (eol) begin
								prim = 1'b1; prim_ev.kind = EV_ERROR;
								prim_ev.line_number = sat_line(lc); prim_ev.code = ki;
								stp = 1'b1;
							end
						end
						default: ph = PH_START;
					endcase
					// raise on ';' waits for the end of the line; raise on any other byte reports at once
					if (ph == PH_ERR_SKIP && phase_q != PH_ERR_SKIP && text_byte != CH_SEMI) begin
						prim = 1'b1; prim_ev.kind = EV_ERROR; prim_ev.code = ki;
						prim_ev.line_number = eol ? sat_line(lc) : lc;
						stp = 1'b1;
					end
					// argument events carry the span captured before the terminator
					if (prim && (phase_q == PH_ARG_NAME || phase_q == PH_VGAP ||
					             phase_q == PH_VALUE)) begin
						prim_ev.kind = EV_ARG; prim_ev.name_offset = ns;
						prim_ev.name_length = nc; prim_ev.has_value = (vc != '0);
						prim_ev.value_offset = (vc != '0) ? vs : '0;
						prim_ev.value_length = vc;
						prim_ev.line_number = lcount_q;
						if (!os) begin
							root = 1'b1; os = 1'b1;
							root_ev.kind = EV_ROOT; root_ev.line_number = lcount_q;
						end
					end
				end
			end
			// end of text: zero byte, or last byte with no stop
			if (text_byte == CH_NUL || (!stp && last)) begin
				case (ph)
					PH_BLANK, PH_LCOMMENT: begin
						if (fmt_q && !ib) begin
							prim = 1'b1; prim_ev = '0; prim_ev.kind = EV_ERROR;
							prim_ev.line_number = lc; prim_ev.code = ERR_STATUS;
						end
					end
					PH_KEYWORD, PH_GAP1, PH_NAME, PH_GAP2, PH_SEEK_EQ, PH_ERR_SKIP: begin
						prim = 1'b1; prim_ev = '0; prim_ev.kind = EV_ERROR;
						prim_ev.line_number = lc;
						case (ph)
							PH_KEYWORD:  prim_ev.code = ERR_NO_DEFINE;
							PH_GAP1:     prim_ev.code = ERR_NO_NAME;
							PH_SEEK_EQ:  prim_ev.code = ERR_NO_EQUALS;
							PH_ERR_SKIP: prim_ev.code = ki;
							default:     prim_ev.code = objerr;
						endcase
					end
					PH_TRAIL_OBJ: begin
						prim = 1'b1; prim_ev = '0; prim_ev.kind = EV_OBJECT;
						prim_ev.name_offset = ns; prim_ev.name_length = nc;
						prim_ev.line_number = lc; ib = 1'b1; os = 1'b1;
					end
					PH_TRAIL_CLOSE: ib = 1'b0;
					PH_ARG_NAME, PH_VGAP, PH_VALUE: begin
						prim = 1'b1; prim_ev = '0; prim_ev.kind = EV_ARG;
						prim_ev.name_offset = ns; prim_ev.name_length = nc;
						prim_ev.has_value = (vc != '0);
						prim_ev.value_offset = (vc != '0) ? vs : '0;
						prim_ev.value_length = vc; prim_ev.line_number = lc;
						if (!os) begin
							root = 1'b1; os = 1'b1;
							root_ev = '0; root_ev.kind = EV_ROOT; root_ev.line_number = lc;
						end
					end
					default: ;
				endcase
				ph = PH_START; stp = 1'b1;
			end
			bp = sat_ofs(bp);
		end
	end

	// queue push: root event first when present
	always_comb begin
		push.valid     = accept && (prim || root);
		push.entry.two = prim && root;
		push.entry.ev0 = root ? root_ev : prim_ev;
		push.entry.ev1 = prim_ev;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START; kidx_q <= '0; bpos_q <= '0; lcount_q <= '0;
			nstart_q <= '0; ncount_q <= '0; vstart_q <= '0; vcount_q <= '0;
			in_body_q <= 1'b0; obj_seen_q <= 1'b0; pcr_q <= 1'b0; stopped_q <= 1'b0;
			fmt_q <= 1'b0; sia_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FORMAT)
					fmt_q <= cfg_data;
				else begin
					sia_q <= cfg_data;
					if (bpos_q == '0 && !stopped_q)
						in_body_q <= cfg_data;
				end
			end
			if (accept) begin
				if (last) begin
					phase_q <= PH_START; kidx_q <= '0; bpos_q <= '0; lcount_q <= '0;
					nstart_q <= '0; ncount_q <= '0; vstart_q <= '0; vcount_q <= '0;
					in_body_q <= sia_q; obj_seen_q <= 1'b0; pcr_q <= 1'b0;
					stopped_q <= 1'b0;
				end else begin
					phase_q <= ph; kidx_q <= ki; bpos_q <= bp; lcount_q <= lc;
					nstart_q <= ns; ncount_q <= nc; vstart_q <= vs; vcount_q <= vc;
					in_body_q <= ib; obj_seen_q <= os; pcr_q <= pcr; stopped_q <= stp;
				end
			end
		end
	end

endmodule

// ===== rtl/mclt_queue.sv =====
// Short event queue between parser and output stage; one entry per byte with events.
// Depends on mclt_pkg.
module mclt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  mclt_pkg::push_t  push,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output mclt_pkg::entry_t head
);
	import mclt_pkg::*;

	entry_t               mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full       = (count_q == (QPTR_BITS+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wptr_q] <= push.entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0; rptr_q <= '0; count_q <= '0;
		end else begin
			if (push.valid)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && full)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid)) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

// ===== rtl/mclt_back.sv =====
// Back end: output register that delivers queued events one beat at a time.
// Depends on mclt_pkg.
module mclt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  mclt_pkg::entry_t head,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output mclt_pkg::event_t ev,
	output logic             run_last
);
	import mclt_pkg::*;

	logic   sel_q, valid_q, last_q, load;
	event_t ev_q;

	assign load      = !valid_q || !out_stall;
	assign pop       = load && head_valid && (sel_q || !head.two);
	assign out_valid = valid_q;
	assign ev        = ev_q;
	assign run_last  = last_q;

	// payload
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			ev_q   <= sel_q ? head.ev1 : head.ev0;
			last_q <= sel_q || !head.two;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0; sel_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid)
				sel_q <= !(sel_q || !head.two);
		end
	end

	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> head_valid && head.two) else $error("second event without pair");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |=> valid_q && $stable(ev_q)) else $error("beat lost");
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> last_q) else $error("pop without last event");

endmodule

// ===== rtl/monitor_config_line_tokenizer.sv =====
// Config line tokenizer: one text byte per beat in, span events out.
// Path: an event is written into the event queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full (in_stall); a byte with two events
// leaves them one after the other from the single output register draining the 4-entry event queue.
// Reset: arst_n clears parser, queue and output; config resets to define format.
// Depends on mclt_pkg, mclt_front, mclt_queue, mclt_back.
module monitor_config_line_tokenizer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       text_byte,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       event_kind,
	output logic [mclt_pkg::OFFSET_BITS-1:0] name_offset,
	output logic [mclt_pkg::OFFSET_BITS-1:0] name_length,
	output logic [mclt_pkg::OFFSET_BITS-1:0] value_offset,
	output logic [mclt_pkg::OFFSET_BITS-1:0] value_length,
	output logic                             has_value,
	output logic [mclt_pkg::LINE_BITS-1:0]   line_number,
	output logic [2:0]                       error_code,
	output logic                             run_last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic                             cfg_data
);
	import mclt_pkg::*;

	push_t  push;
	entry_t head;
	event_t ev;
	logic   full, head_valid, pop, accept;

	assign in_stall  = full;
	assign accept    = in_valid && !full;
	assign cfg_ready = 1'b1;

	mclt_front u_front (
		.clk, .arst_n, .accept, .text_byte, .last,
		.cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data, .push
	);

	mclt_queue u_queue (
		.clk, .arst_n, .push, .pop, .full, .head_valid, .head
	);

	mclt_back u_back (
		.clk, .arst_n, .head_valid, .head, .pop, .out_stall, .out_valid, .ev, .run_last
	);

	// unpack result fields
	assign event_kind   = ev.kind;
	assign name_offset  = ev.name_offset;
	assign name_length  = ev.name_length;
	assign value_offset = ev.value_offset;
	assign value_length = ev.value_length;
	assign has_value    = ev.has_value;
	assign line_number  = ev.line_number;
	assign error_code   = ev.code;

endmodule
